// ===== rtl/mean_square_level_meter_core_macros.svh =====
// ----------------------------------------------------------------------------
// mean square level meter assertion macros
// shared concurrent assertion forms for the meter checker
// ----------------------------------------------------------------------------
`ifndef MEAN_SQUARE_LEVEL_METER_CORE_MACROS_SVH
`define MEAN_SQUARE_LEVEL_METER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define MSL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("meter check failed");

// next-cycle implication, off during reset
`define MSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("meter check failed");

// next-cycle implication, also checked while reset is applied
`define MSL_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk_i) (ante) |=> (cons)) \
    else $error("meter check failed");

`endif

// ===== rtl/msl_pkg.sv =====
// ----------------------------------------------------------------------------
// msl_pkg
// shared widths, types and codes of the mean square level meter
// ----------------------------------------------------------------------------
package msl_pkg;

  localparam int MaxFrameSamples = 4096;

  localparam int SampleW = 16;
  localparam int SqW     = 2 * SampleW;
  localparam int AmpW    = 31;
  localparam int HeightW = 10;
  localparam int MeanW   = 31;
  localparam int CountW  = $clog2(MaxFrameSamples + 1);
  localparam int SumW    = MeanW + $clog2(MaxFrameSamples);
  localparam int ProdW   = MeanW + HeightW;

  // shared divider sizes
  localparam int DivNumW = (SumW > ProdW) ? SumW : ProdW;
  localparam int DivDenW = (AmpW > CountW) ? AmpW : CountW;
  localparam int DivCntW = $clog2(DivNumW + 1);

  // frame queue
  localparam int QDepth  = 2;
  localparam int QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW   = $clog2(QDepth + 1);

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = AmpW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxAmplitude = 1'b0,
    CfgMaxHeight    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkMean,
    BkMul,
    BkBarGo,
    BkBar,
    BkOut
  } bk_state_e;

  // totals of one finished frame
  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
  } frame_t;

endpackage

// ===== rtl/msl_divider.sv =====
// ----------------------------------------------------------------------------
// msl_divider
// restoring divider, one quotient bit per cycle, shared by both divisions
// ----------------------------------------------------------------------------
module msl_divider
  import msl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quot_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivNumW-1:0] num_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;

  logic [DivDenW:0]   rem_sh;
  logic               q_bit;
  logic [DivDenW:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_q, num_q[DivNumW-1]};
    q_bit   = (rem_sh >= {1'b0, den_q});
    rem_sub = q_bit ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DivCntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivNumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DivNumW-2:0], q_bit};
      rem_q <= rem_sub[DivDenW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== rtl/msl_fifo.sv =====
// ----------------------------------------------------------------------------
// msl_fifo
// short queue of finished frame totals between front and back
// ----------------------------------------------------------------------------
module msl_fifo
  import msl_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output frame_t data_o
);

  frame_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q;
  logic [QPtrW-1:0]   rd_ptr_q;
  logic [QCntW-1:0]   cnt_q;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    ptr_inc = (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/msl_front.sv =====
// ----------------------------------------------------------------------------
// msl_front
// squares incoming samples and accumulates frame totals
// ----------------------------------------------------------------------------
module msl_front
  import msl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic               last_sample_i,
  output logic               full_o,
  input  logic               q_full_i,
  output logic               frame_valid_o,
  output frame_t             frame_o
);

  logic              a_valid_q;
  logic              a_last_q;
  logic [SqW-1:0]    sq_q;
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] count_q;

  logic               a_adv;
  logic               accept;
  logic [SampleW-1:0] mag;
  logic               take;
  logic [SumW-1:0]    sum_nx;
  logic [CountW-1:0]  cnt_nx;

  // square stage holds only while its frame end finds the queue full
  assign a_adv  = !(a_valid_q && a_last_q && q_full_i);
  assign full_o = !a_adv;
  assign accept = push_i && a_adv;
  assign mag    = sample_i[SampleW-1] ? (~sample_i + SampleW'(1)) : sample_i;

  always_comb begin
    take   = a_valid_q && (count_q < CountW'(MaxFrameSamples));
    sum_nx = take ? (sum_q + SumW'(sq_q)) : sum_q;
    cnt_nx = take ? (count_q + CountW'(1)) : count_q;
  end

  assign frame_valid_o = a_valid_q && a_last_q && !q_full_i;
  assign frame_o       = '{sum: sum_nx, count: cnt_nx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_last_q  <= 1'b0;
      sum_q     <= '0;
      count_q   <= '0;
    end else begin
      if (a_adv) begin
        a_valid_q <= accept;
        if (accept) begin
          a_last_q <= last_sample_i;
        end
      end
      if (a_valid_q && a_adv) begin
        if (a_last_q) begin
          sum_q   <= '0;
          count_q <= '0;
        end else begin
          sum_q   <= sum_nx;
          count_q <= cnt_nx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q <= mag * mag;
    end
  end

endmodule

// ===== rtl/msl_back.sv =====
// ----------------------------------------------------------------------------
// msl_back
// per-frame mean and bar height through a shared divider, result register
// ----------------------------------------------------------------------------
module msl_back
  import msl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  frame_t             frame_i,
  output logic               q_pop_o,
  input  logic [AmpW-1:0]    max_amp_i,
  input  logic [HeightW-1:0] max_height_i,
  output logic               out_valid_o,
  input  logic               out_pop_i,
  output logic [MeanW-1:0]   mean_o,
  output logic [HeightW-1:0] bar_o
);

  bk_state_e state_q, state_d;

  logic [MeanW-1:0]   mean_q;
  logic [ProdW-1:0]   prod_q;
  logic [HeightW-1:0] bar_q;
  logic               out_valid_q;
  logic [MeanW-1:0]   out_mean_q;
  logic [HeightW-1:0] out_bar_q;

  logic               div_start;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic               div_done;
  logic [DivNumW-1:0] div_quot;
  logic               over;
  logic [ProdW-1:0]   prod_d;
  logic [HeightW-1:0] bar_sat;

  msl_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign over    = (mean_q > max_amp_i);
  assign prod_d  = ProdW'(max_height_i) * ProdW'(mean_q);
  assign bar_sat = (div_quot > DivNumW'(max_height_i)) ? max_height_i
                                                        : div_quot[HeightW-1:0];

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    div_num   = DivNumW'(prod_q);
    div_den   = DivDenW'(max_amp_i);
    unique case (state_q)
      BkIdle: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          div_start = 1'b1;
          div_num   = DivNumW'(frame_i.sum);
          div_den   = DivDenW'(frame_i.count);
          state_d   = BkMean;
        end
      end
      BkMean: begin
        if (div_done) begin
          state_d = BkMul;
        end
      end
      BkMul: begin
        state_d = BkBarGo;
      end
      BkBarGo: begin
        if (over || (max_amp_i == '0)) begin
          state_d = BkOut;
        end else begin
          div_start = 1'b1;
          state_d   = BkBar;
        end
      end
      BkBar: begin
        if (div_done) begin
          state_d = BkOut;
        end
      end
      BkOut: begin
        if (!out_valid_q) begin
          state_d = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BkOut && !out_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BkMean && div_done) begin
      mean_q <= div_quot[MeanW-1:0];
    end
    if (state_q == BkMul) begin
      prod_q <= prod_d;
    end
    if (state_q == BkBarGo) begin
      if (over) begin
        bar_q <= max_height_i;
      end else if (max_amp_i == '0) begin
        bar_q <= '0;
      end
    end
    if (state_q == BkBar && div_done) begin
      bar_q <= bar_sat;
    end
    if (state_q == BkOut && !out_valid_q) begin
      out_mean_q <= mean_q;
      out_bar_q  <= bar_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_o      = out_mean_q;
  assign bar_o       = out_bar_q;

endmodule

// ===== rtl/mean_square_level_meter_core.sv =====
// ----------------------------------------------------------------------------
// mean_square_level_meter_core
// frame mean square energy and bar height of a signed 16-bit sample stream
// ----------------------------------------------------------------------------
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------------
//   samples  | push / full              | sample_i, last_sample_i
//   results  | empty / pop              | mean_energy_o, bar_height_o
//   config   | cfg_we_i, cfg_idx_i      | cfg_data_i (max_amplitude, max_height)
//
// one sample per cycle enters the square and accumulate front end while full is low
// a frame that leaves the frame queue passes through the bit-serial divider, which
// first forms the mean and then the bar height; the bar division is skipped when
// the energy is over full scale or full scale is zero; the back end takes no new
// frame until the last one is in the result register, after the previous result is popped
// full rises only when a frame end meets a full two-entry frame queue
// reset is asynchronous, active low, and leaves the meter ready at once
// ----------------------------------------------------------------------------
module mean_square_level_meter_core
  import msl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample channel
  input  logic                push,
  output logic                full,
  input  logic [SampleW-1:0]  sample_i,
  input  logic                last_sample_i,
  // result channel
  output logic                empty,
  input  logic                pop,
  output logic [MeanW-1:0]    mean_energy_o,
  output logic [HeightW-1:0]  bar_height_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers; the user must write them only while the meter is idle, the block does not enforce it
  logic [AmpW-1:0]    max_amp_q;
  logic [HeightW-1:0] max_height_q;

  // front to queue
  logic   frame_valid;
  frame_t frame_in;
  logic   q_full;

  // queue to back
  logic   q_empty;
  logic   q_pop;
  frame_t frame_out;

  logic   out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_amp_q    <= AmpW'(16777216);
      max_height_q <= HeightW'(128);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMaxAmplitude: max_amp_q    <= cfg_data_i[AmpW-1:0];
        CfgMaxHeight:    max_height_q <= cfg_data_i[HeightW-1:0];
        default:         ;
      endcase
    end
  end

  // square and accumulate, one transfer per cycle while full is low
  msl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .full_o        (full),
    .q_full_i      (q_full),
    .frame_valid_o (frame_valid),
    .frame_o       (frame_in)
  );

  // decouples frame ends from the slow divisions
  msl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frame_valid),
    .data_i  (frame_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (frame_out)
  );

  // mean, product, bar height and the result register
  msl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .frame_i      (frame_out),
    .q_pop_o      (q_pop),
    .max_amp_i    (max_amp_q),
    .max_height_i (max_height_q),
    .out_valid_o  (out_valid),
    .out_pop_i    (pop),
    .mean_o       (mean_energy_o),
    .bar_o        (bar_height_o)
  );

  assign empty = !out_valid;

endmodule

// ===== rtl/msl_checker.sv =====
// ----------------------------------------------------------------------------
// msl_checker
// port-level checks of the meter, bound to the top level
// ----------------------------------------------------------------------------
`include "mean_square_level_meter_core_macros.svh"

module msl_checker
  import msl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [MeanW-1:0]    mean_energy_o,
  input logic [HeightW-1:0]  bar_height_o
);

  // a waiting result holds until its transfer
  `MSL_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(mean_energy_o) && $stable(bar_height_o))

  // a single result register: a transfer always drains it
  `MSL_ASSERT_NEXT(a_pop_drains, !empty && pop, empty)

  // the mean of squares of 16-bit samples never passes 2**30
  `MSL_ASSERT_NOW(a_mean_range, !empty, mean_energy_o <= MeanW'(1073741824))

  // reset leaves no result and accepts samples
  `MSL_ASSERT_ALWAYS(a_reset_state, !rst_ni, empty && !full)

endmodule

bind mean_square_level_meter_core msl_checker u_msl_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the mean square level meter: samples are pushed in
// bursts, results are popped on a changing stall pattern, and every result is
// compared with a typed-in value or a bit-exact predictor of frame energy and bar height
// ----------------------------------------------------------------------------
module tb;
  import msl_pkg::*;

  // reset values of the two scaling registers
  localparam logic [AmpW-1:0]    AmpAtReset    = 31'd16777216;
  localparam logic [HeightW-1:0] HeightAtReset = 10'd128;

  // run shape
  localparam int RandomItems    = 1500;
  localparam int HoldoffCycles  = 500;  // long receiver stall
  localparam int SettleCycles   = 120;  // pause after the last result is back
  localparam int TailCycles     = 200;
  localparam int WatchdogLimit  = 4000; // cycles without any transfer
  localparam int MaxPrinted     = 40;

  typedef struct packed {
    logic [MeanW-1:0]   mean;
    logic [HeightW-1:0] bar;
  } meter_result_t;

  // one row of the directed table; known rows carry a typed-in result
  typedef struct packed {
    logic [SampleW-1:0] smp;
    logic               lst;
    logic               known;
    logic [MeanW-1:0]   mean;
    logic [HeightW-1:0] bar;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // block ports, all known from time zero
  // ---------------------------------------------------------------------------
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                push          = 1'b0;
  logic                full;
  logic [SampleW-1:0]  sample_i      = '0;
  logic                last_sample_i = 1'b0;
  logic                empty;
  logic                pop           = 1'b0;
  logic [MeanW-1:0]    mean_energy_o;
  logic [HeightW-1:0]  bar_height_o;
  logic                cfg_we_i      = 1'b0;
  cfg_idx_e            cfg_idx_i     = CfgMaxAmplitude;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // typed-in result travelling with the item on the sample channel
  logic               item_known = 1'b0;
  logic [MeanW-1:0]   item_mean  = '0;
  logic [HeightW-1:0] item_bar   = '0;

  mean_square_level_meter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .empty         (empty),
    .pop           (pop),
    .mean_energy_o (mean_energy_o),
    .bar_height_o  (bar_height_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: scaling registers and the running frame totals
  // ---------------------------------------------------------------------------
  logic [AmpW-1:0]    scale_amp    = AmpAtReset;
  logic [HeightW-1:0] scale_height = HeightAtReset;
  logic [SumW-1:0]    frame_sum    = '0;
  logic [CountW-1:0]  frame_count  = '0;

  meter_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  int            mismatch_count = 0;
  int            idle_cycles    = 0;

  // sender idling
  int burst_left = 0;
  int gap_max    = 4;
  bit steady     = 1'b0;

  // receiver hold-off request, cleared by the receiver when the stall is over
  bit holdoff_req = 1'b0;

  // accumulate one sample; on a frame end form mean energy and bar height
  function automatic bit accumulate_frame(input logic [SampleW-1:0] smp, input logic lst,
                                          output meter_result_t res);
    logic [SampleW:0]  mag;
    logic [SumW-1:0]   mean_full;
    longint unsigned   scaled;
    // magnitude in one extra bit so that -32768 fits
    mag = smp[SampleW-1] ? ({(SampleW+1){1'b0}} - {1'b1, smp}) : {1'b0, smp};
    res = '0;
    // samples past the frame limit leave the totals alone
    if (frame_count < MaxFrameSamples) begin
      frame_sum   = frame_sum + SumW'(mag) * SumW'(mag);
      frame_count = frame_count + 1'b1;
    end
    if (!lst) return 1'b0;
    mean_full = (frame_count != 0) ? frame_sum / SumW'(frame_count) : '0;
    res.mean  = mean_full[MeanW-1:0];
    if (mean_full > SumW'(scale_amp)) begin
      // energy over full scale pins the bar at the top
      res.bar = scale_height;
    end else if (scale_amp == '0) begin
      res.bar = '0;
    end else begin
      scaled = (64'(scale_height) * 64'(mean_full)) / 64'(scale_amp);
      if (scaled > 64'(scale_height)) scaled = 64'(scale_height);
      res.bar = scaled[HeightW-1:0];
    end
    frame_sum   = '0;
    frame_count = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count < MaxPrinted)
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // transfer monitor: predicts on sample transfers, checks result transfers
  // and runs the watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    meter_result_t res;
    meter_result_t want;
    if (rst_ni) begin
      if (push && !full) begin
        if (accumulate_frame(sample_i, last_sample_i, res)) begin
          if (item_known) begin
            res.mean = item_mean;
            res.bar  = item_bar;
          end
          pending_results.push_back(res);
        end
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, mean", mean_energy_o, 0);
        end else begin
          want = pending_results.pop_front();
          if (mean_energy_o !== want.mean) report_mismatch("mean_energy", mean_energy_o, want.mean);
          if (bar_height_o !== want.bar) report_mismatch("bar_height", bar_height_o, want.bar);
        end
      end
      if ((push && !full) || (pop && !empty) || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: no transfer for %0d cycles", WatchdogLimit);
        $display("** mean_square_level_meter_core: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: changing stall pattern, long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int pop_mode;
    int rx_cycle;
    pop_mode = 0;
    rx_cycle = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (holdoff_req) begin
        // hold off while the sender keeps offering, so full must rise
        pop <= 1'b0;
        repeat (HoldoffCycles) @(posedge clk_i);
        holdoff_req = 1'b0;
      end else begin
        if (rx_cycle % 256 == 0) pop_mode = $urandom_range(0, 3);
        case (pop_mode)
          0: pop <= 1'b1;                              // no stalls
          1: pop <= 1'($urandom_range(0, 1));          // coin flip
          2: pop <= (rx_cycle % 4 == 0);               // one pop in four
          default: pop <= ($urandom_range(0, 9) != 0); // rare stalls
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // offer one sample and wait for its transfer; gaps fall between bursts
  task automatic send_item(input logic [SampleW-1:0] smp, input logic lst, input logic known,
                           input logic [MeanW-1:0] mean, input logic [HeightW-1:0] bar);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap        = steady ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push          <= 1'b1;
    sample_i      <= smp;
    last_sample_i <= lst;
    item_known    <= known;
    item_mean     <= mean;
    item_bar      <= bar;
    do @(posedge clk_i); while (full);
  endtask

  function automatic logic [SampleW-1:0] pick_sample(input int shape);
    logic [SampleW-1:0] raw;
    raw = SampleW'($urandom);
    case (shape)
      0: return raw;                                            // full range
      1: return $signed(raw) >>> $urandom_range(1, 15);         // quieter
      2: begin
        case ($urandom_range(0, 4))                             // extremes
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      default: return $signed(raw) >>> 8;                       // near silence
    endcase
  endfunction

  function automatic int pick_frame_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 40);
    return $urandom_range(41, 200);
  endfunction

  // one frame of random content; shape 4 repeats a single value
  task automatic send_frame(input int len, input int shape);
    logic [SampleW-1:0] steady_val;
    steady_val = SampleW'($urandom);
    for (int i = 0; i < len; i++)
      send_item((shape == 4) ? steady_val : pick_sample(shape), i == len - 1, 1'b0, '0, '0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CfgMaxAmplitude) scale_amp = val;
    else scale_height = val[HeightW-1:0];
  endtask

  // sender pause until every result is back and the back end has gone quiet
  task automatic settle_idle;
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic add_row(input logic [SampleW-1:0] smp, input logic lst, input logic known,
                         input logic [MeanW-1:0] mean, input logic [HeightW-1:0] bar);
    directed_rows.push_back('{smp, lst, known, mean, bar});
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int random_items;
    int phase;
    int len;
    logic [AmpW-1:0]    amp;
    logic [HeightW-1:0] hgt;
    random_items = 0;
    phase        = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset scaling: full scale 2^24, height 128
    add_row(16'h0000, 1'b1, 1'b1, 31'd0,          10'd0);   // silence
    add_row(16'h8000, 1'b1, 1'b1, 31'd1073741824, 10'd128); // most negative
    add_row(16'h7FFF, 1'b1, 1'b1, 31'd1073676289, 10'd128); // most positive
    add_row(16'd4096, 1'b1, 1'b1, 31'd16777216,   10'd128); // energy at full scale
    add_row(16'd4097, 1'b1, 1'b1, 31'd16785409,   10'd128); // just over, forced
    add_row(16'd2048, 1'b1, 1'b1, 31'd4194304,    10'd32);  // quarter scale
    add_row(16'd1,    1'b1, 1'b1, 31'd1,          10'd0);
    add_row(16'd1448, 1'b1, 1'b0, '0, '0);                  // bar rounds down
    add_row(16'd3,    1'b0, 1'b0, '0, '0);                  // two-sample frame
    add_row(16'hFFFC, 1'b1, 1'b0, '0, '0);
    add_row(16'd1,    1'b0, 1'b0, '0, '0);                  // mean truncates
    add_row(16'd2,    1'b1, 1'b0, '0, '0);
    add_row(16'hFFFF, 1'b0, 1'b0, '0, '0);                  // mixed extremes
    add_row(16'h0000, 1'b0, 1'b0, '0, '0);
    add_row(16'h7FFF, 1'b0, 1'b0, '0, '0);
    add_row(16'h8000, 1'b1, 1'b0, '0, '0);
    add_row(16'h5555, 1'b0, 1'b0, '0, '0);                  // alternating bits
    add_row(16'hAAAA, 1'b1, 1'b0, '0, '0);
    foreach (directed_rows[i])
      send_item(directed_rows[i].smp, directed_rows[i].lst, directed_rows[i].known,
                directed_rows[i].mean, directed_rows[i].bar);

    // backpressure: receiver holds off while short frames keep coming
    holdoff_req = 1'b1;
    repeat (30) send_frame(1, $urandom_range(0, 4));

    // frame too long: 4096 loud samples, then ignored ones, last flag on an ignored one
    settle_idle();
    steady = 1'b1;
    for (int i = 0; i < MaxFrameSamples; i++)
      send_item($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF, 1'b0, 1'b0, '0, '0);
    send_item(SampleW'($urandom), 1'b0, 1'b0, '0, '0);
    send_item(SampleW'($urandom), 1'b0, 1'b0, '0, '0);
    send_item(SampleW'($urandom), 1'b1, 1'b0, '0, '0);

    // random phases, each under its own scaling; extremes come first
    while (random_items < RandomItems) begin
      settle_idle();
      case (phase)
        0: begin amp = 31'd1;          hgt = 10'd1023; end
        1: begin amp = 31'd0;          hgt = 10'd1023; end // out of range full scale
        2: begin amp = 31'd1073741824; hgt = 10'd0;    end // out of range height
        3: begin amp = 31'h7FFFFFFF;   hgt = 10'd1023; end
        4: begin amp = 31'd1073741824; hgt = 10'd1;    end
        default: begin
          amp = 31'($urandom) >> $urandom_range(0, 30);
          if (amp == '0) amp = 31'd1;
          hgt = HeightW'($urandom_range(1, 1023));
        end
      endcase
      write_reg(CfgMaxAmplitude, amp);
      write_reg(CfgMaxHeight, 31'(hgt));
      steady  = (phase % 4 == 3);
      gap_max = $urandom_range(1, 12);
      repeat ($urandom_range(8, 24)) begin
        len = pick_frame_len();
        send_frame(len, $urandom_range(0, 4));
        random_items += len;
      end
      phase++;
    end
    push <= 1'b0;

    // let the last frames through, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("** mean_square_level_meter_core: PASSED **");
    else
      $display("** mean_square_level_meter_core: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/msl_pkg.sv
rtl/msl_divider.sv
rtl/msl_fifo.sv
rtl/msl_front.sv
rtl/msl_back.sv
rtl/mean_square_level_meter_core.sv
rtl/msl_checker.sv
tb/tb.sv
